// ===== hw/rtl/fcbb_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbb_pkg
// shared types and constants of the frame change bounding box
// ----------------------------------------------------------------------------
package fcbb_pkg;

    localparam int PIXEL_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int RECT_POS_W  = 10;
    localparam int RECT_SIZE_W = 11;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_OPTIMIZE     = 2'd2
    } t_cfg_reg;

    // per-word frame control passed from the position counter to the tracker
    typedef struct packed {
        logic sof;   // first pixel of a frame
        logic eof;   // last pixel of a frame
        logic cmp;   // compare against the stored frame
    } t_frame_ctl;

endpackage

// ===== hw/rtl/frame_change_bounding_box.sv =====
// ----------------------------------------------------------------------------
// frame_change_bounding_box
// bounding rectangle of pixels that differ from the previous frame
// ----------------------------------------------------------------------------
// throughput: one pixel word per clock; input stalls only while a result
//   waits in the output register and another frame end reaches the compare
// result path: after the last pixel of a frame the rectangle passes the
//   store read and compare register, then the result register
// reset: counters, latches and valid flags cleared; the frame store is not
//   cleared and needs no pass, each entry is compared only after it was written
// ----------------------------------------------------------------------------
module frame_change_bounding_box #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [fcbb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fcbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [fcbb_pkg::PIXEL_W-1:0]     i_pixel_value,
    // rectangle output
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [fcbb_pkg::RECT_POS_W-1:0]  o_rect_x,
    output logic [fcbb_pkg::RECT_POS_W-1:0]  o_rect_y,
    output logic [fcbb_pkg::RECT_SIZE_W-1:0] o_rect_w,
    output logic [fcbb_pkg::RECT_SIZE_W-1:0] o_rect_h
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                         accept;
    logic                         hold;
    logic [AW-1:0]                addr;
    logic                         store_we;
    logic [CW-1:0]                col;
    logic [LW-1:0]                line;
    fcbb_pkg::t_frame_ctl         ctl;
    logic [WW-1:0]                width_eff;
    logic [HW-1:0]                height_eff;
    logic [fcbb_pkg::PIXEL_W-1:0] prev_pixel;

    // a word is taken whenever the compare stage can move
    assign accept  = i_valid && !hold;
    assign o_stall = hold;

    // position counters, frame latches and register file
    fcbb_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .o_addr       (addr),
        .o_we         (store_we),
        .o_col        (col),
        .o_line       (line),
        .o_ctl        (ctl),
        .o_width_eff  (width_eff),
        .o_height_eff (height_eff)
    );

    // previous frame store: read old pixel and write new one at one address
    fcbb_ram #(
        .WIDTH (fcbb_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (addr),
        .i_wdata (i_pixel_value),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (prev_pixel)
    );

    // compare, track the box, hold the result
    fcbb_box #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_box (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_pixel      (i_pixel_value),
        .i_col        (col),
        .i_line       (line),
        .i_ctl        (ctl),
        .i_prev_pixel (prev_pixel),
        .i_width_eff  (width_eff),
        .i_height_eff (height_eff),
        .i_stall      (i_stall),
        .o_hold       (hold),
        .o_valid      (o_valid),
        .o_rect_x     (o_rect_x),
        .o_rect_y     (o_rect_y),
        .o_rect_w     (o_rect_w),
        .o_rect_h     (o_rect_h)
    );

endmodule

// ===== hw/rtl/fcbb_ram.sv =====
// ----------------------------------------------------------------------------
// fcbb_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module fcbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents when read and write hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fcbb_pos.sv =====
// ----------------------------------------------------------------------------
// fcbb_pos
// configuration registers, raster position counters and per-frame latches
// ----------------------------------------------------------------------------
module fcbb_pos #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fcbb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fcbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_accept,
    output logic [AW-1:0]                    o_addr,
    output logic                             o_we,
    output logic [CW-1:0]                    o_col,
    output logic [LW-1:0]                    o_line,
    output fcbb_pkg::t_frame_ctl             o_ctl,
    output logic [WW-1:0]                    o_width_eff,
    output logic [HW-1:0]                    o_height_eff
);

    logic [WW-1:0] r_width_eff;
    logic [HW-1:0] r_height_eff;
    logic          r_optimize;
    logic          r_have_prev;
    logic          r_opt_latch;
    logic          r_cmp_latch;
    logic [CW-1:0] r_col;
    logic [LW-1:0] r_line;

    logic          sof;
    logic          opt_now;
    logic          cmp_now;
    logic          end_line;
    logic          end_frame;

    assign sof       = (r_col == '0) && (r_line == '0);
    assign opt_now   = sof ? r_optimize : r_opt_latch;
    assign cmp_now   = sof ? (r_optimize && r_have_prev) : r_cmp_latch;
    assign end_line  = (WW'(r_col) + WW'(1)) >= r_width_eff;
    assign end_frame = end_line && ((HW'(r_line) + HW'(1)) >= r_height_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_eff  <= WW'(1);
            r_height_eff <= HW'(1);
            r_optimize   <= 1'b0;
            r_have_prev  <= 1'b0;
            r_opt_latch  <= 1'b0;
            r_cmp_latch  <= 1'b0;
            r_col        <= '0;
            r_line       <= '0;
        end else if (i_cfg_we) begin
            unique case (fcbb_pkg::t_cfg_reg'(i_cfg_index))
                fcbb_pkg::CFG_FRAME_WIDTH: begin
                    // zero acts as one, above the maximum saturates
                    if (i_cfg_data == '0) begin
                        r_width_eff <= WW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                        r_width_eff <= WW'(MAX_WIDTH);
                    end else begin
                        r_width_eff <= WW'(i_cfg_data);
                    end
                    r_have_prev <= 1'b0;
                    r_opt_latch <= 1'b0;
                    r_cmp_latch <= 1'b0;
                end
                fcbb_pkg::CFG_FRAME_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_height_eff <= HW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                        r_height_eff <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height_eff <= HW'(i_cfg_data);
                    end
                    r_have_prev <= 1'b0;
                    r_opt_latch <= 1'b0;
                    r_cmp_latch <= 1'b0;
                end
                fcbb_pkg::CFG_OPTIMIZE: begin
                    r_optimize <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_opt_latch <= opt_now;
            r_cmp_latch <= cmp_now;
            if (!end_line) begin
                r_col <= r_col + CW'(1);
            end else begin
                r_col <= '0;
                if (!end_frame) begin
                    r_line <= r_line + LW'(1);
                end else begin
                    r_line <= '0;
                    if (opt_now) begin
                        r_have_prev <= 1'b1;
                    end
                end
            end
        end
    end

    // store address by constant multiply, no divider needed
    assign o_addr       = AW'(r_line) * AW'(MAX_WIDTH) + AW'(r_col);
    assign o_we         = i_accept && opt_now;
    assign o_col        = r_col;
    assign o_line       = r_line;
    assign o_ctl.sof    = sof;
    assign o_ctl.eof    = end_frame;
    assign o_ctl.cmp    = cmp_now;
    assign o_width_eff  = r_width_eff;
    assign o_height_eff = r_height_eff;

endmodule

// ===== hw/rtl/fcbb_box.sv =====
// ----------------------------------------------------------------------------
// fcbb_box
// compare stage, bounding box tracker and result register
// ----------------------------------------------------------------------------
module fcbb_box #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [fcbb_pkg::PIXEL_W-1:0]     i_pixel,
    input  logic [CW-1:0]                    i_col,
    input  logic [LW-1:0]                    i_line,
    input  fcbb_pkg::t_frame_ctl             i_ctl,
    input  logic [fcbb_pkg::PIXEL_W-1:0]     i_prev_pixel,
    input  logic [WW-1:0]                    i_width_eff,
    input  logic [HW-1:0]                    i_height_eff,
    input  logic                             i_stall,
    output logic                             o_hold,
    output logic                             o_valid,
    output logic [fcbb_pkg::RECT_POS_W-1:0]  o_rect_x,
    output logic [fcbb_pkg::RECT_POS_W-1:0]  o_rect_y,
    output logic [fcbb_pkg::RECT_SIZE_W-1:0] o_rect_w,
    output logic [fcbb_pkg::RECT_SIZE_W-1:0] o_rect_h
);

    logic                             r_s1_valid;
    logic [fcbb_pkg::PIXEL_W-1:0]     r_s1_pixel;
    logic [CW-1:0]                    r_s1_col;
    logic [LW-1:0]                    r_s1_line;
    fcbb_pkg::t_frame_ctl             r_s1_ctl;

    logic                             r_seen;
    logic [CW-1:0]                    r_min_col;
    logic [CW-1:0]                    r_max_col;
    logic [LW-1:0]                    r_min_line;
    logic [LW-1:0]                    r_max_line;

    logic                             r_out_valid;
    logic [fcbb_pkg::RECT_POS_W-1:0]  r_rect_x;
    logic [fcbb_pkg::RECT_POS_W-1:0]  r_rect_y;
    logic [fcbb_pkg::RECT_SIZE_W-1:0] r_rect_w;
    logic [fcbb_pkg::RECT_SIZE_W-1:0] r_rect_h;

    logic                             hold;
    logic                             fire;
    logic                             out_free;
    logic                             diff;
    logic                             base_seen;
    logic                             n_seen;
    logic [CW-1:0]                    n_min_col;
    logic [CW-1:0]                    n_max_col;
    logic [LW-1:0]                    n_min_line;
    logic [LW-1:0]                    n_max_line;
    logic [CW:0]                      span_w;
    logic [LW:0]                      span_h;

    assign out_free = !(r_out_valid && i_stall);
    assign hold     = r_s1_valid && r_s1_ctl.eof && !out_free;
    assign fire     = r_s1_valid && !hold;

    always_comb begin
        diff       = r_s1_ctl.cmp && (i_prev_pixel != r_s1_pixel);
        base_seen  = r_s1_ctl.sof ? 1'b0 : r_seen;
        n_seen     = base_seen || diff;
        n_min_col  = r_min_col;
        n_max_col  = r_max_col;
        n_min_line = r_min_line;
        n_max_line = r_max_line;
        if (diff) begin
            if (!base_seen) begin
                n_min_col  = r_s1_col;
                n_max_col  = r_s1_col;
                n_min_line = r_s1_line;
                n_max_line = r_s1_line;
            end else begin
                if (r_s1_col < r_min_col)   n_min_col  = r_s1_col;
                if (r_s1_col > r_max_col)   n_max_col  = r_s1_col;
                if (r_s1_line < r_min_line) n_min_line = r_s1_line;
                if (r_s1_line > r_max_line) n_max_line = r_s1_line;
            end
        end
        span_w = {1'b0, n_max_col} - {1'b0, n_min_col} + (CW + 1)'(1);
        span_h = {1'b0, n_max_line} - {1'b0, n_min_line} + (LW + 1)'(1);
    end

    // compare stage, aligned with the registered store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!hold) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= i_col;
            r_s1_line  <= i_line;
            r_s1_ctl   <= i_ctl;
        end
    end

    // change tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (fire) begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_min_col  <= n_min_col;
            r_max_col  <= n_max_col;
            r_min_line <= n_min_line;
            r_max_line <= n_max_line;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && r_s1_ctl.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && r_s1_ctl.eof) begin
            if (!r_s1_ctl.cmp) begin
                // full frame
                r_rect_x <= '0;
                r_rect_y <= '0;
                r_rect_w <= fcbb_pkg::RECT_SIZE_W'(i_width_eff);
                r_rect_h <= fcbb_pkg::RECT_SIZE_W'(i_height_eff);
            end else if (!n_seen) begin
                // nothing changed
                r_rect_x <= '0;
                r_rect_y <= '0;
                r_rect_w <= fcbb_pkg::RECT_SIZE_W'(1);
                r_rect_h <= fcbb_pkg::RECT_SIZE_W'(1);
            end else begin
                r_rect_x <= fcbb_pkg::RECT_POS_W'(n_min_col);
                r_rect_y <= fcbb_pkg::RECT_POS_W'(n_min_line);
                r_rect_w <= fcbb_pkg::RECT_SIZE_W'(span_w);
                r_rect_h <= fcbb_pkg::RECT_SIZE_W'(span_h);
            end
        end
    end

    assign o_hold   = hold;
    assign o_valid  = r_out_valid;
    assign o_rect_x = r_rect_x;
    assign o_rect_y = r_rect_y;
    assign o_rect_w = r_rect_w;
    assign o_rect_h = r_rect_h;

    a_hold_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |-> r_out_valid)
        else $error("compare stage held with an empty result register");

    a_result_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_ctl.eof))
        else $error("result without a frame end in the compare stage");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |=> r_s1_valid && $stable(r_s1_col) && $stable(r_s1_line))
        else $error("held compare word changed");

    a_rect_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rect_w != '0) && (r_rect_h != '0))
        else $error("empty rectangle reported");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame change bounding box: pixel words are
// streamed in raster order under random sender and receiver idling, a
// bench-side tracker predicts each rectangle, and every rectangle the block
// returns is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MAX_W        = 1024;
    localparam int unsigned MAX_H        = 1024;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 350;
    localparam int unsigned MAX_PRINTS   = 50;
    // index with no register behind it
    localparam logic [fcbb_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [fcbb_pkg::RECT_POS_W-1:0]  x;
        logic [fcbb_pkg::RECT_POS_W-1:0]  y;
        logic [fcbb_pkg::RECT_SIZE_W-1:0] w;
        logic [fcbb_pkg::RECT_SIZE_W-1:0] h;
    } t_rect;

    typedef enum {FRAME_FRESH, FRAME_REPEAT, FRAME_EDIT} t_frame_kind;

    // dut ports; the inputs are all known from time zero
    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_we      = 1'b0;
    logic [fcbb_pkg::CFG_INDEX_W-1:0] i_cfg_index   = fcbb_pkg::CFG_FRAME_WIDTH;
    logic [fcbb_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                             i_valid       = 1'b0;
    logic                             o_stall;
    logic [fcbb_pkg::PIXEL_W-1:0]     i_pixel_value = '0;
    logic                             o_valid;
    logic                             i_stall       = 1'b0;
    logic [fcbb_pkg::RECT_POS_W-1:0]  o_rect_x;
    logic [fcbb_pkg::RECT_POS_W-1:0]  o_rect_y;
    logic [fcbb_pkg::RECT_SIZE_W-1:0] o_rect_w;
    logic [fcbb_pkg::RECT_SIZE_W-1:0] o_rect_h;

    frame_change_bounding_box #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rect_x      (o_rect_x),
        .o_rect_y      (o_rect_y),
        .o_rect_w      (o_rect_w),
        .o_rect_h      (o_rect_h)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    logic [fcbb_pkg::PIXEL_W-1:0] pixel_fifo [$];     // words waiting for the driver
    t_rect                        pending_rects [$];  // predicted rectangles, oldest first
    int unsigned                  pixels_pushed = 0;
    int unsigned                  pixels_taken  = 0;
    int unsigned                  rects_checked = 0;
    int unsigned                  errors        = 0;
    int unsigned                  cycle_count   = 0;
    bit                           send_idle     = 1'b1;
    bit                           recv_idle     = 1'b1;
    int unsigned                  send_wait     = 0;
    int unsigned                  recv_wait     = 0;
    int unsigned                  hold_count    = 0;
    int unsigned                  holds_asked   = 0;
    int unsigned                  holds_done    = 0;

    // current picture the stimulus is built from, sized to the frame
    logic [fcbb_pkg::PIXEL_W-1:0] scene [];
    int unsigned                  scene_w = 0;
    int unsigned                  scene_h = 0;

    // tracker copy of the block: registers, position, frame store, box
    logic [fcbb_pkg::CFG_DATA_W-1:0] reg_width  = 11'd1;
    logic [fcbb_pkg::CFG_DATA_W-1:0] reg_height = 11'd1;
    bit                              reg_opt    = 1'b0;
    logic [fcbb_pkg::PIXEL_W-1:0]    frame_store [int unsigned];
    bit                              have_prev  = 1'b0;
    bit                              opt_frame  = 1'b0;   // optimize latched at frame start
    bit                              cmp_frame  = 1'b0;   // compare latched at frame start
    bit                              changed    = 1'b0;
    int unsigned                     col_cnt    = 0;
    int unsigned                     line_cnt   = 0;
    int unsigned                     min_col    = 1;
    int unsigned                     min_line   = 1;
    int unsigned                     max_col    = 0;
    int unsigned                     max_line   = 0;

    // ------------------------------------------------------------------------
    // tracker
    // ------------------------------------------------------------------------

    // zero acts as one, anything past the store saturates
    function automatic int unsigned eff_size(logic [fcbb_pkg::CFG_DATA_W-1:0] v,
                                             int unsigned limit);
        if (v == 0) return 1;
        return (v > limit) ? limit : int'(v);
    endfunction

    function automatic void clear_box();
        min_col  = eff_size(reg_width, MAX_W);
        min_line = eff_size(reg_height, MAX_H);
        max_col  = 0;
        max_line = 0;
        changed  = 1'b0;
    endfunction

    function automatic void apply_reg(logic [fcbb_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [fcbb_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fcbb_pkg::CFG_FRAME_WIDTH:  reg_width  = data;
            fcbb_pkg::CFG_FRAME_HEIGHT: reg_height = data;
            fcbb_pkg::CFG_OPTIMIZE: begin
                reg_opt = data[0];
                return;
            end
            default: return;
        endcase
        // any size write drops the stored frame and the current frame's latches
        have_prev = 1'b0;
        opt_frame = 1'b0;
        cmp_frame = 1'b0;
    endfunction

    // one accepted pixel word; a frame end queues its rectangle
    function automatic void track_pixel(logic [fcbb_pkg::PIXEL_W-1:0] pix);
        int unsigned w, h, col, line, addr;
        logic [fcbb_pkg::PIXEL_W-1:0] stored;
        t_rect r;
        w    = eff_size(reg_width, MAX_W);
        h    = eff_size(reg_height, MAX_H);
        col  = col_cnt % MAX_W;
        line = line_cnt % MAX_H;
        addr = line * MAX_W + col;
        if (col_cnt == 0 && line_cnt == 0) begin
            opt_frame = reg_opt;
            cmp_frame = reg_opt && have_prev;
            clear_box();
        end
        stored = frame_store.exists(addr) ? frame_store[addr] : '0;
        if (cmp_frame && stored != pix) begin
            if (col < min_col)   min_col  = col;
            if (col > max_col)   max_col  = col;
            if (line < min_line) min_line = line;
            if (line > max_line) max_line = line;
            changed = 1'b1;
        end
        if (opt_frame) frame_store[addr] = pix;

        if (col_cnt + 1 < w) begin
            col_cnt++;
            return;
        end
        col_cnt = 0;
        if (line_cnt + 1 < h) begin
            line_cnt++;
            return;
        end
        line_cnt = 0;

        if (!cmp_frame) begin
            // full frame
            r.x = '0;
            r.y = '0;
            r.w = fcbb_pkg::RECT_SIZE_W'(w);
            r.h = fcbb_pkg::RECT_SIZE_W'(h);
        end else if (!changed) begin
            // nothing moved
            r.x = '0;
            r.y = '0;
            r.w = 11'd1;
            r.h = 11'd1;
        end else begin
            r.x = fcbb_pkg::RECT_POS_W'(min_col);
            r.y = fcbb_pkg::RECT_POS_W'(min_line);
            r.w = fcbb_pkg::RECT_SIZE_W'(max_col - min_col + 1);
            r.h = fcbb_pkg::RECT_SIZE_W'(max_line - min_line + 1);
        end
        pending_rects.push_back(r);
        if (opt_frame) have_prev = 1'b1;
        opt_frame = 1'b0;
        cmp_frame = 1'b0;
        clear_box();
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d rectangles outstanding",
                     cycle_count, pending_rects.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: offers queued pixel words, holds each one while stalled
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                track_pixel(i_pixel_value);
                pixels_taken++;
            end
            // a stalled word stays put, otherwise gap or next word
            if (!(i_valid && o_stall)) begin
                if (send_wait != 0) begin
                    i_valid   <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pixel_fifo.size() != 0) begin
                    i_valid       <= 1'b1;
                    i_pixel_value <= pixel_fifo.pop_front();
                    send_wait     <= send_idle ? $urandom_range(0, 14) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted here on request of the stimulus
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_count <= 0;
            holds_done <= 0;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end else if (holds_done != holds_asked) begin
            hold_count <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each accepted rectangle, then draws its own stall
    // ------------------------------------------------------------------------
    task automatic report(string what, int unsigned got, int unsigned want);
        if (errors < MAX_PRINTS)
            $display("mismatch %s: got %0d, expected %0d (rectangle %0d)",
                     what, got, want, rects_checked);
        errors++;
    endtask

    always @(posedge i_clk) begin
        int unsigned next_wait;
        t_rect want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_rects.size() == 0) begin
                    report("unexpected rectangle, x", o_rect_x, 0);
                end else begin
                    want = pending_rects.pop_front();
                    if (o_rect_x != want.x) report("rect_x", o_rect_x, want.x);
                    if (o_rect_y != want.y) report("rect_y", o_rect_y, want.y);
                    if (o_rect_w != want.w) report("rect_w", o_rect_w, want.w);
                    if (o_rect_h != want.h) report("rect_h", o_rect_h, want.h);
                end
                rects_checked++;
                next_wait = recv_idle ? $urandom_range(0, 14) : 0;
            end else begin
                next_wait = (recv_wait != 0) ? recv_wait - 1 : 0;
            end
            recv_wait <= next_wait;
            i_stall   <= (next_wait != 0) || (hold_count != 0);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // register write while the block is idle; a gap with write enable low keeps writes apart
    task automatic write_reg(logic [fcbb_pkg::CFG_INDEX_W-1:0] idx,
                             logic [fcbb_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    // all words taken and every rectangle back, then the block's latency
    task automatic settle();
        while (pixels_taken != pixels_pushed || pending_rects.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [fcbb_pkg::PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_pixel(logic [fcbb_pkg::PIXEL_W-1:0] pix);
        pixel_fifo.push_back(pix);
        pixels_pushed++;
    endfunction

    // picture follows the frame size, a new size starts a new picture
    function automatic void fit_scene();
        int unsigned w, h;
        w = eff_size(reg_width, MAX_W);
        h = eff_size(reg_height, MAX_H);
        if (w != scene_w || h != scene_h) begin
            scene_w = w;
            scene_h = h;
            scene   = new[w * h];
            foreach (scene[i]) scene[i] = rand_pixel();
        end
    endfunction

    task automatic send_part(int unsigned first, int unsigned last);
        for (int unsigned i = first; i <= last; i++) push_pixel(scene[i]);
    endtask

    task automatic send_frame(t_frame_kind kind, int unsigned edits);
        fit_scene();
        case (kind)
            FRAME_FRESH: foreach (scene[i]) scene[i] = rand_pixel();
            FRAME_EDIT: begin
                repeat (edits)
                    scene[$urandom_range(0, scene.size() - 1)] ^= 32'd1 << $urandom_range(0, 31);
            end
            default: ;
        endcase
        send_part(0, scene.size() - 1);
    endtask

    // random words one by one until the tracker sits at a frame start
    task automatic finish_frame();
        while (col_cnt != 0 || line_cnt != 0) begin
            push_pixel(rand_pixel());
            while (pixels_taken != pixels_pushed) @(posedge i_clk);
        end
    endtask

    task automatic set_size(logic [fcbb_pkg::CFG_DATA_W-1:0] w,
                            logic [fcbb_pkg::CFG_DATA_W-1:0] h);
        write_reg(fcbb_pkg::CFG_FRAME_WIDTH, w);
        write_reg(fcbb_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_start, nframes, cut, pick;
        t_frame_kind kind;

        clear_box();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: 1x1 frames, optimize off, so full-frame rectangles
        push_pixel('0);
        push_pixel('1);
        settle();

        // 1x1 with optimize: first frame full, then unchanged, then changed
        write_reg(fcbb_pkg::CFG_OPTIMIZE, 11'd1);
        push_pixel(32'h1234_5678);
        push_pixel(32'h1234_5678);
        push_pixel(32'h8765_4321);
        settle();

        // 3x2: full, unchanged, changes at opposite corners, single change
        set_size(11'd3, 11'd2);
        send_frame(FRAME_FRESH, 0);
        send_frame(FRAME_REPEAT, 0);
        scene[0] ^= 32'h0000_0001;
        scene[5] ^= 32'h8000_0000;
        send_frame(FRAME_REPEAT, 0);
        scene[4] ^= 32'hffff_ffff;
        send_frame(FRAME_REPEAT, 0);
        settle();

        // optimize dropped mid-frame: the value latched at frame start holds
        scene[1] ^= 32'h00ff_00ff;
        send_part(0, 2);
        settle();
        write_reg(fcbb_pkg::CFG_OPTIMIZE, 11'd0);
        send_part(3, 5);
        settle();
        // optimize off: full frame, nothing stored
        scene[3] ^= 32'h0000_0100;
        send_frame(FRAME_REPEAT, 0);
        settle();
        // back on: compares with the last frame stored while optimize was on
        write_reg(fcbb_pkg::CFG_OPTIMIZE, 11'd1);
        send_frame(FRAME_REPEAT, 0);
        settle();

        // width shrinks mid-line with the column past the new width
        write_reg(fcbb_pkg::CFG_FRAME_WIDTH, 11'd4);
        send_frame(FRAME_FRESH, 0);
        fit_scene();
        send_part(0, 2);
        settle();
        write_reg(fcbb_pkg::CFG_FRAME_WIDTH, 11'd2);
        finish_frame();
        settle();

        // zero sizes act as one
        set_size(11'd0, 11'd0);
        push_pixel(32'hdead_beef);
        push_pixel(32'hdead_beef);
        push_pixel(32'h0000_0000);
        settle();

        // sizes past the limit saturate; a size write part way through the
        // first line cuts the frame short at once
        send_idle = 1'b0;
        recv_idle = 1'b0;
        set_size(11'h7ff, 11'h7ff);
        repeat (20) push_pixel(rand_pixel());
        settle();
        set_size(11'd5, 11'd1);
        finish_frame();
        settle();

        // short lines with no idling; unused index changes nothing
        send_frame(FRAME_FRESH, 0);
        settle();
        write_reg(CFG_UNUSED, 11'h7ff);
        scene[4] ^= 32'h0000_0001;
        send_frame(FRAME_REPEAT, 0);
        scene[0] ^= 32'h8000_0000;
        scene[4] ^= 32'h0000_0001;
        send_frame(FRAME_REPEAT, 0);
        settle();

        // receiver holds off while 1x1 frames keep coming: the block fills up
        set_size(11'd1, 11'd1);
        write_reg(fcbb_pkg::CFG_OPTIMIZE, 11'd1);
        holds_asked++;
        repeat (40) push_pixel(rand_pixel());
        settle();
        send_idle = 1'b1;
        recv_idle = 1'b1;

        // random phases: mostly runs of related frames, some noise and breaks
        random_start = pixels_pushed;
        while (pixels_pushed - random_start < RANDOM_ITEMS) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 15))
                    0:       write_reg(fcbb_pkg::CFG_FRAME_WIDTH, 11'd0);
                    1:       write_reg(fcbb_pkg::CFG_FRAME_WIDTH, 11'($urandom_range(9, 48)));
                    default: write_reg(fcbb_pkg::CFG_FRAME_WIDTH, 11'($urandom_range(1, 8)));
                endcase
                if ($urandom_range(0, 15) == 0)
                    write_reg(fcbb_pkg::CFG_FRAME_HEIGHT, 11'd0);
                else
                    write_reg(fcbb_pkg::CFG_FRAME_HEIGHT, 11'($urandom_range(1, 6)));
            end
            write_reg(fcbb_pkg::CFG_OPTIMIZE, 11'($urandom_range(0, 3) != 0));

            nframes = $urandom_range(1, 5);
            for (int unsigned f = 0;
                 f < nframes && pixels_pushed - random_start < RANDOM_ITEMS; f++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)      kind = FRAME_FRESH;
                else if (pick < 3)  kind = FRAME_REPEAT;
                else                kind = FRAME_EDIT;
                send_frame(kind, $urandom_range(1, 3));
            end
            settle();

            // broken frame: register write part way through, then run it out
            fit_scene();
            if ($urandom_range(0, 5) == 0 && scene.size() > 1) begin
                cut = $urandom_range(0, scene.size() - 2);
                send_part(0, cut);
                settle();
                case ($urandom_range(0, 2))
                    0: write_reg(fcbb_pkg::CFG_OPTIMIZE, 11'($urandom_range(0, 1)));
                    1: write_reg(fcbb_pkg::CFG_FRAME_WIDTH, 11'($urandom_range(1, 8)));
                    default: write_reg(fcbb_pkg::CFG_FRAME_HEIGHT, 11'($urandom_range(1, 6)));
                endcase
                finish_frame();
                settle();
            end
        end

        // second hold-off with short lines to end on
        set_size(11'd2, 11'd1);
        holds_asked++;
        send_idle = 1'b0;
        repeat (60) push_pixel(rand_pixel());
        settle();

        $display("%0d pixel words sent, %0d rectangles checked, %0d mismatches",
                 pixels_pushed, rects_checked, errors);
        $display("covered small and saturated sizes, optimize on and off, frames cut short,");
        $display("mid-frame register writes and %0d long receiver hold-offs", holds_done);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
